@@ design/sip_pkg.sv @@
// ----------------------------------------------------------------------------
// sip_pkg
// shared widths, types and the side-band record of the segment intersection
// pipeline
// ----------------------------------------------------------------------------
package sip_pkg;

    // coordinate and derived widths
    localparam int CW  = 32;          // coordinate, signed fixed point
    localparam int DW  = CW + 1;      // coordinate difference, signed
    localparam int XW  = 2 * DW;      // cross product, signed
    localparam int MW  = XW - 1;      // cross product magnitude
    localparam int PW  = MW + CW;     // scaled numerator magnitude
    localparam int QW  = CW;          // quotient bits
    localparam int TW  = 16;          // tolerance register
    localparam int BW  = CW + 2;      // box compare width
    localparam int NPT = 8;           // coordinates per request

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [XW-1:0] cross_t;
    typedef logic signed [BW-1:0] box_t;
    typedef logic [MW-1:0]        mag_t;
    typedef logic [CW-1:0]        umag_t;
    typedef logic [PW-1:0]        prod_t;
    typedef logic [QW-1:0]        quot_t;
    typedef logic [TW-1:0]        tol_t;
    typedef logic [NPT-1:0][CW-1:0] pts_t;

    // per-request outcome carried alongside the arithmetic
    typedef struct packed {
        logic   use_quot; // point comes from the parametric quotient
        logic   hit;
        coord_t base_x;   // endpoint, or segment A start on the crossing path
        coord_t base_y;
        logic   neg_x;    // quotient sign for x
        logic   neg_y;
    } sip_side_t;

endpackage

@@ design/sip_front.sv @@
// ----------------------------------------------------------------------------
// sip_front
// four stages: differences and box tests, cross products, cross product
// subtraction, classification into crossing / endpoint / miss
// ----------------------------------------------------------------------------
module sip_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  sip_pkg::pts_t     in_pts,
    input  sip_pkg::tol_t     tol,
    output logic              out_valid,
    output sip_pkg::sip_side_t out_side,
    output sip_pkg::mag_t     out_num,
    output sip_pkg::mag_t     out_den,
    output sip_pkg::umag_t    out_dxa,
    output sip_pkg::umag_t    out_dya
);
    import sip_pkg::*;

    function automatic coord_t cmin(coord_t a, coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t cmax(coord_t a, coord_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic box_t bx(coord_t a);
        return box_t'(a);
    endfunction

    function automatic diff_t dsub(coord_t a, coord_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

    function automatic logic in_box(coord_t ax, coord_t ay, coord_t bx2, coord_t by2,
                                    coord_t px, coord_t py, box_t t);
        return (bx(cmin(ax, bx2)) - t <= bx(px)) && (bx(px) <= bx(cmax(ax, bx2)) + t) &&
               (bx(cmin(ay, by2)) - t <= bx(py)) && (bx(py) <= bx(cmax(ay, by2)) + t);
    endfunction

    function automatic mag_t absm(cross_t v);
        cross_t n;
        n = -v;
        return v[XW-1] ? n[MW-1:0] : v[MW-1:0];
    endfunction

    function automatic logic opp(cross_t a, cross_t b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    function automatic umag_t absd(diff_t v);
        diff_t n;
        n = -v;
        return v[DW-1] ? n[CW-1:0] : v[CW-1:0];
    endfunction

    // stage 1 inputs
    coord_t x1, y1, x2, y2, x3, y3, x4, y4;
    box_t   tb;
    logic   reject;

    assign x1 = coord_t'(in_pts[0]);
    assign y1 = coord_t'(in_pts[1]);
    assign x2 = coord_t'(in_pts[2]);
    assign y2 = coord_t'(in_pts[3]);
    assign x3 = coord_t'(in_pts[4]);
    assign y3 = coord_t'(in_pts[5]);
    assign x4 = coord_t'(in_pts[6]);
    assign y4 = coord_t'(in_pts[7]);
    assign tb = box_t'({1'b0, tol});

    // widened bounding boxes that do not overlap
    assign reject = (bx(cmax(x1, x2)) + tb < bx(cmin(x3, x4))) ||
                    (bx(cmax(x3, x4)) + tb < bx(cmin(x1, x2))) ||
                    (bx(cmax(y1, y2)) + tb < bx(cmin(y3, y4))) ||
                    (bx(cmax(y3, y4)) + tb < bx(cmin(y1, y2)));

    // stage 1 registers
    logic       v1_reg, rej1_reg;
    logic [3:0] ib1_reg;
    pts_t       pt1_reg;
    diff_t      dxa1_reg, dya1_reg, dxb1_reg, dyb1_reg;
    diff_t      e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    diff_t      e3x_reg, e3y_reg, e4x_reg, e4y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt1_reg  <= in_pts;
            rej1_reg <= reject;
            ib1_reg  <= {in_box(x1, y1, x2, y2, x4, y4, tb),
                         in_box(x1, y1, x2, y2, x3, y3, tb),
                         in_box(x3, y3, x4, y4, x2, y2, tb),
                         in_box(x3, y3, x4, y4, x1, y1, tb)};
            dxa1_reg <= dsub(x2, x1);
            dya1_reg <= dsub(y2, y1);
            dxb1_reg <= dsub(x4, x3);
            dyb1_reg <= dsub(y4, y3);
            e1x_reg  <= dsub(x1, x3);
            e1y_reg  <= dsub(y1, y3);
            e2x_reg  <= dsub(x2, x3);
            e2y_reg  <= dsub(y2, y3);
            e3x_reg  <= dsub(x3, x1);
            e3y_reg  <= dsub(y3, y1);
            e4x_reg  <= dsub(x4, x1);
            e4y_reg  <= dsub(y4, y1);
        end
    end

    // stage 2: ten products
    logic       v2_reg, rej2_reg;
    logic [3:0] ib2_reg;
    pts_t       pt2_reg;
    diff_t      dxa2_reg, dya2_reg;
    cross_t     m1a_reg, m1b_reg, m2a_reg, m2b_reg, m3a_reg, m3b_reg;
    cross_t     m4a_reg, m4b_reg, mna_reg, mnb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt2_reg  <= pt1_reg;
            rej2_reg <= rej1_reg;
            ib2_reg  <= ib1_reg;
            dxa2_reg <= dxa1_reg;
            dya2_reg <= dya1_reg;
            m1a_reg  <= cross_t'(dxb1_reg) * cross_t'(e1y_reg);
            m1b_reg  <= cross_t'(dyb1_reg) * cross_t'(e1x_reg);
            m2a_reg  <= cross_t'(dxb1_reg) * cross_t'(e2y_reg);
            m2b_reg  <= cross_t'(dyb1_reg) * cross_t'(e2x_reg);
            m3a_reg  <= cross_t'(dxa1_reg) * cross_t'(e3y_reg);
            m3b_reg  <= cross_t'(dya1_reg) * cross_t'(e3x_reg);
            m4a_reg  <= cross_t'(dxa1_reg) * cross_t'(e4y_reg);
            m4b_reg  <= cross_t'(dya1_reg) * cross_t'(e4x_reg);
            mna_reg  <= cross_t'(dxa1_reg) * cross_t'(dyb1_reg);
            mnb_reg  <= cross_t'(dya1_reg) * cross_t'(dxb1_reg);
        end
    end

    // stage 3: cross products and denominator (d1 doubles as numerator)
    logic       v3_reg, rej3_reg;
    logic [3:0] ib3_reg;
    pts_t       pt3_reg;
    diff_t      dxa3_reg, dya3_reg;
    cross_t     d1_reg, d2_reg, d3_reg, d4_reg, den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt3_reg  <= pt2_reg;
            rej3_reg <= rej2_reg;
            ib3_reg  <= ib2_reg;
            dxa3_reg <= dxa2_reg;
            dya3_reg <= dya2_reg;
            d1_reg   <= m1a_reg - m1b_reg;
            d2_reg   <= m2a_reg - m2b_reg;
            d3_reg   <= m3a_reg - m3b_reg;
            d4_reg   <= m4a_reg - m4b_reg;
            den_reg  <= mna_reg - mnb_reg;
        end
    end

    // stage 4: classification
    mag_t      tolm;
    logic      crossing;
    sip_side_t side_next;

    assign tolm     = mag_t'(tol);
    assign crossing = opp(d1_reg, d2_reg) && opp(d3_reg, d4_reg);

    always_comb begin
        side_next.use_quot = 1'b0;
        side_next.hit      = 1'b0;
        side_next.base_x   = coord_t'(pt3_reg[0]);
        side_next.base_y   = coord_t'(pt3_reg[1]);
        side_next.neg_x    = d1_reg[XW-1] ^ dxa3_reg[DW-1] ^ den_reg[XW-1];
        side_next.neg_y    = d1_reg[XW-1] ^ dya3_reg[DW-1] ^ den_reg[XW-1];
        priority if (rej3_reg) begin
            side_next.hit = 1'b0;
        end else if (crossing) begin
            side_next.use_quot = 1'b1;
            side_next.hit      = absm(den_reg) > tolm;
        end else if (absm(d1_reg) <= tolm && ib3_reg[0]) begin
            side_next.hit = 1'b1;
        end else if (absm(d2_reg) <= tolm && ib3_reg[1]) begin
            side_next.hit    = 1'b1;
            side_next.base_x = coord_t'(pt3_reg[2]);
            side_next.base_y = coord_t'(pt3_reg[3]);
        end else if (absm(d3_reg) <= tolm && ib3_reg[2]) begin
            side_next.hit    = 1'b1;
            side_next.base_x = coord_t'(pt3_reg[4]);
            side_next.base_y = coord_t'(pt3_reg[5]);
        end else if (absm(d4_reg) <= tolm && ib3_reg[3]) begin
            side_next.hit    = 1'b1;
            side_next.base_x = coord_t'(pt3_reg[6]);
            side_next.base_y = coord_t'(pt3_reg[7]);
        end else begin
            side_next.hit = 1'b0;
        end
    end

    logic      v4_reg;
    sip_side_t side4_reg;
    mag_t      num4_reg, den4_reg;
    umag_t     dxa4_reg, dya4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side4_reg <= side_next;
            num4_reg  <= absm(d1_reg);
            den4_reg  <= absm(den_reg);
            dxa4_reg  <= absd(dxa3_reg);
            dya4_reg  <= absd(dya3_reg);
        end
    end

    assign out_valid = v4_reg;
    assign out_side  = side4_reg;
    assign out_num   = num4_reg;
    assign out_den   = den4_reg;
    assign out_dxa   = dxa4_reg;
    assign out_dya   = dya4_reg;

endmodule

@@ design/sip_scale.sv @@
// ----------------------------------------------------------------------------
// sip_scale
// numerator magnitude times segment A span, as partial products over two
// stages
// ----------------------------------------------------------------------------
module sip_scale (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  sip_pkg::sip_side_t in_side,
    input  sip_pkg::mag_t      in_num,
    input  sip_pkg::mag_t      in_den,
    input  sip_pkg::umag_t     in_dxa,
    input  sip_pkg::umag_t     in_dya,
    output logic               out_valid,
    output sip_pkg::sip_side_t out_side,
    output sip_pkg::mag_t      out_den,
    output sip_pkg::prod_t     out_px,
    output sip_pkg::prod_t     out_py
);
    import sip_pkg::*;

    typedef logic [2*CW-1:0] pp_t;

    // stage a: partial products on the low and middle numerator words
    logic      va_reg, topa_reg;
    sip_side_t sidea_reg;
    mag_t      dena_reg;
    umag_t     dxa_reg, dya_reg;
    pp_t       x0_reg, x1_reg, y0_reg, y1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sidea_reg <= in_side;
            dena_reg  <= in_den;
            dxa_reg   <= in_dxa;
            dya_reg   <= in_dya;
            topa_reg  <= in_num[2*CW];
            x0_reg    <= pp_t'(in_num[CW-1:0])    * pp_t'(in_dxa);
            x1_reg    <= pp_t'(in_num[2*CW-1:CW]) * pp_t'(in_dxa);
            y0_reg    <= pp_t'(in_num[CW-1:0])    * pp_t'(in_dya);
            y1_reg    <= pp_t'(in_num[2*CW-1:CW]) * pp_t'(in_dya);
        end
    end

    // stage b: sum of the shifted partial products
    logic      vb_reg;
    sip_side_t sideb_reg;
    mag_t      denb_reg;
    prod_t     px_reg, py_reg;
    prod_t     topx, topy;

    assign topx = topa_reg ? (prod_t'(dxa_reg) << (2*CW)) : '0;
    assign topy = topa_reg ? (prod_t'(dya_reg) << (2*CW)) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sideb_reg <= sidea_reg;
            denb_reg  <= dena_reg;
            px_reg    <= prod_t'(x0_reg) + (prod_t'(x1_reg) << CW) + topx;
            py_reg    <= prod_t'(y0_reg) + (prod_t'(y1_reg) << CW) + topy;
        end
    end

    assign out_valid = vb_reg;
    assign out_side  = sideb_reg;
    assign out_den   = denb_reg;
    assign out_px    = px_reg;
    assign out_py    = py_reg;

endmodule

@@ design/sip_divider.sv @@
// ----------------------------------------------------------------------------
// sip_divider
// pipelined restoring divider, one quotient bit per stage for x and y
// ----------------------------------------------------------------------------
module sip_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  sip_pkg::sip_side_t in_side,
    input  sip_pkg::mag_t      in_den,
    input  sip_pkg::prod_t     in_px,
    input  sip_pkg::prod_t     in_py,
    output logic               out_valid,
    output sip_pkg::sip_side_t out_side,
    output sip_pkg::quot_t     out_qx,
    output sip_pkg::quot_t     out_qy
);
    import sip_pkg::*;

    typedef logic [MW:0] sh_t;

    // one trial subtraction: returns new remainder and quotient bit
    function automatic logic [MW:0] div_step(mag_t rem, logic nbit, mag_t den);
        sh_t sh;
        sh_t df;
        sh = {rem, nbit};
        df = sh - {1'b0, den};
        return (sh >= {1'b0, den}) ? {1'b1, df[MW-1:0]} : {1'b0, sh[MW-1:0]};
    endfunction

    logic      v_in   [QW];
    sip_side_t s_in   [QW];
    mag_t      d_in   [QW];
    mag_t      rx_in  [QW], ry_in [QW];
    quot_t     lx_in  [QW], ly_in [QW];
    quot_t     qx_in  [QW], qy_in [QW];

    logic      v_reg  [QW];
    sip_side_t s_reg  [QW];
    mag_t      d_reg  [QW];
    mag_t      rx_reg [QW], ry_reg [QW];
    quot_t     lx_reg [QW], ly_reg [QW];
    quot_t     qx_reg [QW], qy_reg [QW];

    // stage inputs: the first from the ports, the rest from the stage before
    assign v_in[0]  = in_valid;
    assign s_in[0]  = in_side;
    assign d_in[0]  = in_den;
    assign rx_in[0] = in_px[PW-1:QW];
    assign ry_in[0] = in_py[PW-1:QW];
    assign lx_in[0] = in_px[QW-1:0];
    assign ly_in[0] = in_py[QW-1:0];
    assign qx_in[0] = '0;
    assign qy_in[0] = '0;

    for (genvar k = 1; k < QW; k++) begin : g_link
        assign v_in[k]  = v_reg[k-1];
        assign s_in[k]  = s_reg[k-1];
        assign d_in[k]  = d_reg[k-1];
        assign rx_in[k] = rx_reg[k-1];
        assign ry_in[k] = ry_reg[k-1];
        assign lx_in[k] = lx_reg[k-1];
        assign ly_in[k] = ly_reg[k-1];
        assign qx_in[k] = qx_reg[k-1];
        assign qy_in[k] = qy_reg[k-1];
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [MW:0] stx, sty;

        assign stx = div_step(rx_in[k], lx_in[k][QW-1], d_in[k]);
        assign sty = div_step(ry_in[k], ly_in[k][QW-1], d_in[k]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[k]  <= s_in[k];
                d_reg[k]  <= d_in[k];
                rx_reg[k] <= stx[MW-1:0];
                ry_reg[k] <= sty[MW-1:0];
                lx_reg[k] <= lx_in[k] << 1;
                ly_reg[k] <= ly_in[k] << 1;
                qx_reg[k] <= {qx_in[k][QW-2:0], stx[MW]};
                qy_reg[k] <= {qy_in[k][QW-2:0], sty[MW]};
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_side  = s_reg[QW-1];
    assign out_qx    = qx_reg[QW-1];
    assign out_qy    = qy_reg[QW-1];

endmodule

@@ design/segment_intersection_point_unit.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_point_unit
// streaming test of two 2-D segments for a meeting point, fully pipelined
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tdata: segment A start/end, segment B start/end (x,y)
//  m_*       out        tdata: point x, point y; tuser: hit
//  cfg_*     in         data: tolerance in LSBs
//
//  one request per cycle unless the output stalls; a request passes the 4 front
//  stages, 2 scaling stages, 32 divider stages and the output register to
//  reach m_tvalid. all stages advance together and hold while the output waits.
//  aresetn clears the valid bits and sets the tolerance to zero.
// ----------------------------------------------------------------------------
module segment_intersection_point_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [8*sip_pkg::CW-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // point_x, point_y
    output logic [2*sip_pkg::CW-1:0] m_tdata,
    // hit
    output logic                    m_tuser,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [sip_pkg::TW-1:0]  cfg_data
);
    import sip_pkg::*;

    typedef logic signed [CW+1:0] sum_t;

    logic en;
    tol_t tol_reg;

    // pipeline advances when the output register is free or drained
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    logic      f_valid;
    sip_side_t f_side;
    mag_t      f_num, f_den;
    umag_t     f_dxa, f_dya;

    sip_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_pts    (pts_t'(s_tdata)),
        .tol       (tol_reg),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_num   (f_num),
        .out_den   (f_den),
        .out_dxa   (f_dxa),
        .out_dya   (f_dya)
    );

    logic      c_valid;
    sip_side_t c_side;
    mag_t      c_den;
    prod_t     c_px, c_py;

    sip_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_num    (f_num),
        .in_den    (f_den),
        .in_dxa    (f_dxa),
        .in_dya    (f_dya),
        .out_valid (c_valid),
        .out_side  (c_side),
        .out_den   (c_den),
        .out_px    (c_px),
        .out_py    (c_py)
    );

    logic      q_valid;
    sip_side_t q_side;
    quot_t     q_x, q_y;

    sip_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid),
        .in_side   (c_side),
        .in_den    (c_den),
        .in_px     (c_px),
        .in_py     (c_py),
        .out_valid (q_valid),
        .out_side  (q_side),
        .out_qx    (q_x),
        .out_qy    (q_y)
    );

    // final point: signed offset from segment A start, or the chosen endpoint
    sum_t   ofs_x, ofs_y, sum_x, sum_y;
    coord_t pt_x_next, pt_y_next;

    assign ofs_x = q_side.neg_x ? -sum_t'({2'b00, q_x}) : sum_t'({2'b00, q_x});
    assign ofs_y = q_side.neg_y ? -sum_t'({2'b00, q_y}) : sum_t'({2'b00, q_y});
    assign sum_x = sum_t'(q_side.base_x) + ofs_x;
    assign sum_y = sum_t'(q_side.base_y) + ofs_y;

    always_comb begin
        pt_x_next = '0;
        pt_y_next = '0;
        if (q_side.hit) begin
            if (q_side.use_quot) begin
                pt_x_next = sum_x[CW-1:0];
                pt_y_next = sum_y[CW-1:0];
            end else begin
                pt_x_next = q_side.base_x;
                pt_y_next = q_side.base_y;
            end
        end
    end

    // output register
    logic   m_valid_reg, hit_reg;
    coord_t px_reg, py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= q_side.hit;
            px_reg  <= pt_x_next;
            py_reg  <= pt_y_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {py_reg, px_reg};

endmodule

@@ dv/segment_intersection_point_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_point_unit_tb
// self-checking bench for the segment meeting point unit: a directed table,
// then mostly near-origin, collinear and crossing random segment pairs under
// several tolerance settings, with random stalls on both stream sides.
// every accepted request is scored against its typed row or an exact wide-integer predictor.
// ----------------------------------------------------------------------------
module segment_intersection_point_unit_tb;
    import sip_pkg::*;

    localparam int   CLK_PERIOD   = 12;
    localparam int   DRAIN_CYCLES = 45;
    localparam int   WATCHDOG_MAX = 4000;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   RANDOM_ITEMS = 1300;
    localparam int   Q            = 65536;

    typedef logic signed [127:0] wide_t;
    typedef coord_t pair_t [8];   // xa0 ya0 xa1 ya1 xb0 yb0 xb1 yb1

    typedef struct {
        logic   hit;
        coord_t px;
        coord_t py;
    } meeting_t;

    typedef struct {
        pair_t    pts;
        bit       typed;
        meeting_t want;
    } row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [8*CW-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [2*CW-1:0]  m_tdata;
    logic             m_tuser;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [TW-1:0]    cfg_data;

    meeting_t pending_points[$];
    row_t     stim_rows[$];
    tol_t     cur_tol;
    int       mismatches;
    int       quiet_cycles;
    bit       hold_now;
    bit       steady_ready;

    segment_intersection_point_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // exact (b - a) x (c - a)
    function automatic wide_t cross_of(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                       wide_t cx, wide_t cy);
        return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    endfunction

    function automatic bit near_zero(wide_t v, tol_t tol);
        wide_t mag;
        mag = (v < 0) ? -v : v;
        return mag <= wide_t'(tol);
    endfunction

    function automatic bit in_box(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                  wide_t px, wide_t py, tol_t tol);
        wide_t t;
        t = wide_t'(tol);
        return ((ax < bx ? ax : bx) - t <= px) && (px <= (ax > bx ? ax : bx) + t) &&
               ((ay < by ? ay : by) - t <= py) && (py <= (ay > by ? ay : by) + t);
    endfunction

    // expected meeting point for one segment pair
    function automatic meeting_t predict_meeting(pair_t p, tol_t tol);
        wide_t    x1, y1, x2, y2, x3, y3, x4, y4, t;
        wide_t    d1, d2, d3, d4, den, num, qx, qy;
        meeting_t r;
        x1 = p[0]; y1 = p[1]; x2 = p[2]; y2 = p[3];
        x3 = p[4]; y3 = p[5]; x4 = p[6]; y4 = p[7];
        t = wide_t'(tol);
        r = '{hit: 1'b0, px: '0, py: '0};
        // widened bounding box rejection
        if ((x1 > x2 ? x1 : x2) + t < (x3 < x4 ? x3 : x4) ||
            (x3 > x4 ? x3 : x4) + t < (x1 < x2 ? x1 : x2) ||
            (y1 > y2 ? y1 : y2) + t < (y3 < y4 ? y3 : y4) ||
            (y3 > y4 ? y3 : y4) + t < (y1 < y2 ? y1 : y2))
            return r;
        d1 = cross_of(x3, y3, x4, y4, x1, y1);
        d2 = cross_of(x3, y3, x4, y4, x2, y2);
        d3 = cross_of(x1, y1, x2, y2, x3, y3);
        d4 = cross_of(x1, y1, x2, y2, x4, y4);
        if (((d1 > 0 && d2 < 0) || (d1 < 0 && d2 > 0)) &&
            ((d3 > 0 && d4 < 0) || (d3 < 0 && d4 > 0))) begin
            den = (x2 - x1) * (y4 - y3) - (y2 - y1) * (x4 - x3);
            if (!near_zero(den, tol)) begin
                num = (x3 - x1) * (y4 - y3) - (y3 - y1) * (x4 - x3);
                // signed division truncates toward zero
                qx = (num * (x2 - x1)) / den;
                qy = (num * (y2 - y1)) / den;
                r.hit = 1'b1;
                r.px = coord_t'(x1 + qx);
                r.py = coord_t'(y1 + qy);
            end
        end else if (near_zero(d1, tol) && in_box(x3, y3, x4, y4, x1, y1, tol)) begin
            r = '{hit: 1'b1, px: p[0], py: p[1]};
        end else if (near_zero(d2, tol) && in_box(x3, y3, x4, y4, x2, y2, tol)) begin
            r = '{hit: 1'b1, px: p[2], py: p[3]};
        end else if (near_zero(d3, tol) && in_box(x1, y1, x2, y2, x3, y3, tol)) begin
            r = '{hit: 1'b1, px: p[4], py: p[5]};
        end else if (near_zero(d4, tol) && in_box(x1, y1, x2, y2, x4, y4, tol)) begin
            r = '{hit: 1'b1, px: p[6], py: p[7]};
        end
        return r;
    endfunction

    // short gaps mostly, a long one now and then
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // coordinate near the origin, in units of a quarter
    function automatic coord_t near_coord();
        return coord_t'(($signed($urandom_range(0, 32)) - 16) * (Q / 4));
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int    kind, k0, k1;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 8; i++)
            p[i] = near_coord();
        if (kind < 15) begin
            // full-range noise
            for (int i = 0; i < 8; i++)
                p[i] = coord_t'($urandom);
        end else if (kind < 35) begin
            // segment B on the line of segment A
            k0 = $urandom_range(0, 6) - 1;
            k1 = $urandom_range(0, 6) - 1;
            p[0] = coord_t'($signed($urandom_range(0, 64)) - 32);
            p[1] = coord_t'($signed($urandom_range(0, 64)) - 32);
            p[2] = p[0] + coord_t'($signed($urandom_range(0, 8)) - 4) * 4;
            p[3] = p[1] + coord_t'($signed($urandom_range(0, 8)) - 4) * 4;
            p[4] = p[0] + (p[2] - p[0]) * k0 / 4;
            p[5] = p[1] + (p[3] - p[1]) * k0 / 4;
            p[6] = p[0] + (p[2] - p[0]) * k1 / 4;
            p[7] = p[1] + (p[3] - p[1]) * k1 / 4;
            if ($urandom_range(0, 1)) begin
                p[5] = p[5] + coord_t'($urandom_range(0, 2)) - 1;
            end
        end else if (kind < 45) begin
            // large but crossing through the origin region
            p[0] = coord_t'(-$signed({1'b0, $urandom_range(1, 30000)}) * Q);
            p[2] = coord_t'($signed({1'b0, $urandom_range(1, 30000)}) * Q);
            p[4] = coord_t'($urandom);
            p[5] = p[1] + coord_t'($urandom_range(1, 1 << 30));
            p[7] = p[3] - coord_t'($urandom_range(1, 1 << 30));
        end else if (kind < 50) begin
            // degenerate point segment
            p[6] = p[4];
            p[7] = p[5];
        end
        return p;
    endfunction

    task automatic send_pair(pair_t p, bit typed, meeting_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {p[7], p[6], p[5], p[4], p[3], p[2], p[1], p[0]};
        do @(posedge aclk); while (!s_tready);
        pending_points.push_back(typed ? want : predict_meeting(p, cur_tol));
        @(negedge aclk);
    endtask

    // write the tolerance once the pipeline has drained
    task automatic set_tolerance(tol_t tol);
        s_tvalid = 1'b0;
        @(negedge aclk);
        while (pending_points.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = tol;
        do @(posedge aclk); while (!cfg_ready);
        cur_tol = tol;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_row(int xa0, int ya0, int xa1, int ya1,
                           int xb0, int yb0, int xb1, int yb1,
                           bit typed, logic hit, int px, int py);
        row_t r;
        r.pts   = '{xa0, ya0, xa1, ya1, xb0, yb0, xb1, yb1};
        r.typed = typed;
        r.want  = '{hit: hit, px: px, py: py};
        stim_rows.push_back(r);
    endtask

    // result receiver: random stalls, steady stretches, one long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_now) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_now = 1'b0;
            end
            if (steady_ready) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(0, 3) != 0);
                if (!m_tready) repeat (pick_gap()) @(negedge aclk);
            end
        end
    end

    // result scoreboard
    always @(posedge aclk) begin
        meeting_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit %0b x %h y %h",
                             m_tuser, m_tdata[CW-1:0], m_tdata[2*CW-1:CW]);
            end else begin
                want = pending_points.pop_front();
                if (m_tuser !== want.hit || m_tdata[CW-1:0] !== want.px ||
                    m_tdata[2*CW-1:CW] !== want.py) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: hit %0b/%0b x %h/%h y %h/%h (expected/actual)",
                                 want.hit, m_tuser, want.px, m_tdata[CW-1:0],
                                 want.py, m_tdata[2*CW-1:CW]);
                end
            end
        end
    end

    // watchdog on cycles with no request moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        tol_t tol_steps[5];
        meeting_t none;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cur_tol = '0;
        mismatches = 0;
        quiet_cycles = 0;
        hold_now = 1'b0;
        steady_ready = 1'b0;
        none = '{hit: 1'b0, px: '0, py: '0};
        aresetn = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // directed table: point pair, crossing, miss, overlap, touching, extremes
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 1'b1, 0, 0);
        add_row(0, 0, 2*Q, 2*Q, 0, 2*Q, 2*Q, 0, 1, 1'b1, Q, Q);
        add_row(0, 0, Q, Q, 5*Q, 5*Q, 6*Q, 7*Q, 1, 1'b0, 0, 0);
        add_row(0, 0, 4*Q, 0, 2*Q, 0, 6*Q, 0, 1, 1'b1, 4*Q, 0);
        add_row(0, 0, 2*Q, 0, Q, 0, Q, 2*Q, 0, 1'b0, 0, 0);
        add_row(0, 0, 2*Q, 2*Q, Q, Q, Q, Q, 0, 1'b0, 0, 0);
        add_row(0, 0, 2, 1, 0, 1, 2, 0, 0, 1'b0, 0, 0);
        add_row(0, 0, 4*Q, 0, 0, Q, 4*Q, Q, 1, 1'b0, 0, 0);
        add_row(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0, 1'b0, 0, 0);
        add_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                1, 1'b1, 32'sh7fffffff, 32'sh7fffffff);
        add_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                1, 1'b1, 32'sh80000000, 32'sh80000000);
        add_row(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 1'b0, 0, 0);
        add_row(32'sh80000000, 0, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh80000000,
                32'sh7fffffff, 32'sh7fffffff, 0, 1'b0, 0, 0);

        foreach (stim_rows[i])
            send_pair(stim_rows[i].pts, stim_rows[i].typed, stim_rows[i].want);
        // same table at the widest tolerance; typed rows are re-predicted
        set_tolerance(16'hffff);
        foreach (stim_rows[i])
            send_pair(stim_rows[i].pts, 1'b0, none);

        // random phases across tolerance settings
        tol_steps = '{16'h0000, 16'h0001, tol_t'($urandom), 16'hffff, 16'h0004};
        for (int ph = 0; ph < 5; ph++) begin
            set_tolerance(tol_steps[ph]);
            steady_ready = (ph == 2);
            for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
                if (ph == 1 && n == 20) hold_now = 1'b1;
                send_pair(random_pair(), 1'b0, none);
            end
        end
        steady_ready = 1'b0;
        s_tvalid = 1'b0;

        while (pending_points.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ segment_intersection_point_unit.f @@
design/sip_pkg.sv
design/sip_front.sv
design/sip_scale.sv
design/sip_divider.sv
design/segment_intersection_point_unit.sv
dv/segment_intersection_point_unit_tb.sv
